FILE: sv/smpe_pkg.sv
`default_nettype none
package smpe_pkg;

    // widths of the channel fields, fixed by the item format
    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned MAX_LANES = 4;

    typedef logic signed [FIELD_W-1:0] t_field;

    // per-item control carried alongside the lane data through the pipe
    typedef struct packed {
        logic   new_pair;
        logic   above_valid;
        t_field above_value;
    } t_ctl;

endpackage
`default_nettype wire

FILE: sv/smpe_ifs.sv
`default_nettype none
interface smpe_in_if import smpe_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field act_lane0;
    t_field act_lane1;
    t_field act_lane2;
    t_field act_lane3;
    t_field wt_lane0;
    t_field wt_lane1;
    t_field wt_lane2;
    t_field wt_lane3;
    logic   new_pair;
    logic   above_valid;
    t_field above_value;

    modport source (
        output valid, act_lane0, act_lane1, act_lane2, act_lane3,
               wt_lane0, wt_lane1, wt_lane2, wt_lane3,
               new_pair, above_valid, above_value,
        input  ready
    );
    modport sink (
        input  valid, act_lane0, act_lane1, act_lane2, act_lane3,
               wt_lane0, wt_lane1, wt_lane2, wt_lane3,
               new_pair, above_valid, above_value,
        output ready
    );
endinterface

interface smpe_out_if import smpe_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field out_value;
    logic   from_above;

    modport source (output valid, out_value, from_above, input ready);
    modport sink (input valid, out_value, from_above, output ready);
endinterface

interface smpe_cfg_if import smpe_pkg::*; ();
    logic valid;
    logic ready;
    logic above_enabled;

    modport source (output valid, above_enabled, input ready);
    modport sink (input valid, above_enabled, output ready);
endinterface
`default_nettype wire

FILE: sv/systolic_mac_pe_with_drain.sv
// channel   | dir | modport | carries
// i_in      | in  | sink    | act/wt lanes, new_pair, above offer
// o_out     | out | source  | out_value, from_above
// i_cfg     | in  | sink    | above_enabled write, always ready
//
// one transaction per cycle sustained on i_in while no emitting item waits on a held
// result; an accepted item passes stage a and stage b before any result is registered in the output register
// the four lane multipliers and the merge adder are each one register stage
// i_rst_n is synchronous: clears pipe valids, output valid, sums, sets above_enabled
// a held result stalls only the final stage, and only for items that emit;
// earlier stages keep filling while bubbles remain
`default_nettype none
module systolic_mac_pe_with_drain import smpe_pkg::*; #(
    parameter int unsigned LANES      = 4,
    parameter int unsigned SUM_DEPTH  = 8,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    smpe_in_if.sink    i_in,
    smpe_out_if.source o_out,
    smpe_cfg_if.sink   i_cfg
);

    t_field                w_act  [MAX_LANES];
    t_field                w_wt   [MAX_LANES];
    logic [DATA_WIDTH-1:0] w_prod [LANES];
    logic [DATA_WIDTH-1:0] w_dot;

    logic r_above_en;
    logic r_va;
    logic r_vb;
    logic n_va;
    logic n_vb;
    t_ctl r_ctl_a;
    t_ctl r_ctl_b;
    t_ctl w_ctl_in;

    logic w_ld_a;
    logic w_rdy_a;
    logic w_rdy_b;
    logic w_fire_b;
    logic w_res;
    logic w_free;

    // configuration register, written only while idle: a user rule, not enforced
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above_en <= 1'b1;
        end else if (i_cfg.valid) begin
            r_above_en <= i_cfg.above_enabled;
        end
    end

    // lane data gathered for indexing
    assign w_act[0] = i_in.act_lane0;
    assign w_act[1] = i_in.act_lane1;
    assign w_act[2] = i_in.act_lane2;
    assign w_act[3] = i_in.act_lane3;
    assign w_wt[0]  = i_in.wt_lane0;
    assign w_wt[1]  = i_in.wt_lane1;
    assign w_wt[2]  = i_in.wt_lane2;
    assign w_wt[3]  = i_in.wt_lane3;

    assign w_ctl_in = '{new_pair:    i_in.new_pair,
                        above_valid: i_in.above_valid,
                        above_value: i_in.above_value};

    // pipe handshake: stage a = lane products, stage b = dot product
    // the final step (accumulate + output) fires unless it emits onto a held result
    assign w_res    = r_ctl_b.new_pair || (r_ctl_b.above_valid && r_above_en);
    assign w_fire_b = r_vb && (!w_res || w_free);
    assign w_rdy_b  = !r_vb || w_fire_b;
    assign w_rdy_a  = !r_va || w_rdy_b;
    assign w_ld_a   = i_in.valid && w_rdy_a;

    assign i_in.ready = w_rdy_a;

    assign n_va = w_ld_a || (r_va && !w_rdy_b);
    assign n_vb = (r_va && w_rdy_b) || (r_vb && !w_fire_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= n_va;
            r_vb <= n_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_a) begin
            r_ctl_a <= w_ctl_in;
        end
        if (r_va && w_rdy_b) begin
            r_ctl_b <= r_ctl_a;
        end
    end

    // one multiplier per active lane; higher lanes are ignored
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        smpe_lane #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_ld_a),
            .i_act  (w_act[g]),
            .i_wt   (w_wt[g]),
            .o_prod (w_prod[g])
        );
    end

    smpe_merge #(
        .LANES      (LANES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (r_va && w_rdy_b),
        .i_prod (w_prod),
        .o_dot  (w_dot)
    );

    // sum shift line and output register
    smpe_acc #(
        .SUM_DEPTH  (SUM_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire_b),
        .i_emit  (w_res),
        .i_dot   (w_dot),
        .i_ctl   (r_ctl_b),
        .o_free  (w_free),
        .o_out   (o_out)
    );

    // an emitting item only leaves stage b into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire_b && w_res) |-> w_free)
        else $error("emit into occupied output register");

    // a stalled dot product stays in stage b
    a_hold_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb && !w_fire_b) |=> r_vb)
        else $error("stage b item lost while stalled");

    // a new pair drains its own sum, never a forwarded one
    a_drain_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire_b && r_ctl_b.new_pair) |=> (o_out.valid && !o_out.from_above))
        else $error("new pair did not drain own sum");

    // reset empties the pipe and the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_va && !r_vb && !o_out.valid))
        else $error("pipe not empty after reset");

endmodule
`default_nettype wire

FILE: sv/smpe_lane.sv
`default_nettype none
module smpe_lane import smpe_pkg::*; #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire t_field                i_act,
    input  wire t_field                i_wt,
    output logic [DATA_WIDTH-1:0]      o_prod
);

    logic signed [2*FIELD_W-1:0] w_full;
    logic        [DATA_WIDTH-1:0] r_prod;

    // full signed product, wrapped to the accumulator width
    assign w_full = i_act * i_wt;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_full[DATA_WIDTH-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

FILE: sv/smpe_merge.sv
`default_nettype none
module smpe_merge import smpe_pkg::*; #(
    parameter int unsigned LANES      = 4,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [DATA_WIDTH-1:0] i_prod [LANES],
    output logic [DATA_WIDTH-1:0]      o_dot
);

    logic [DATA_WIDTH-1:0] w_sum;
    logic [DATA_WIDTH-1:0] r_dot;

    // at most four narrow adds, wraps at the accumulator width
    always_comb begin
        w_sum = '0;
        for (int unsigned l = 0; l < LANES; l++) begin
            w_sum = w_sum + i_prod[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dot <= w_sum;
        end
    end

    assign o_dot = r_dot;

endmodule
`default_nettype wire

FILE: sv/smpe_acc.sv
`default_nettype none
module smpe_acc import smpe_pkg::*; #(
    parameter int unsigned SUM_DEPTH  = 8,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_fire,
    input  wire logic                  i_emit,
    input  wire logic [DATA_WIDTH-1:0] i_dot,
    input  wire t_ctl                  i_ctl,
    output logic                       o_free,
    smpe_out_if.source                 o_out
);

    localparam int unsigned EXT_W = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

    logic [DATA_WIDTH-1:0] r_sum [SUM_DEPTH];
    logic [DATA_WIDTH-1:0] w_oldest;
    logic [DATA_WIDTH-1:0] w_next;
    logic [EXT_W-1:0]      w_oldest_ext;
    logic                  r_out_valid;
    t_field                r_out_value;
    logic                  r_from_above;

    assign w_oldest     = r_sum[SUM_DEPTH-1];
    assign w_oldest_ext = EXT_W'(w_oldest);
    assign w_next       = i_dot + (i_ctl.new_pair ? '0 : w_oldest);

    // running sums, newest at entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int unsigned d = 0; d < SUM_DEPTH; d++) begin
                r_sum[d] <= '0;
            end
        end else if (i_fire) begin
            for (int unsigned d = 1; d < SUM_DEPTH; d++) begin
                r_sum[d] <= r_sum[d-1];
            end
            r_sum[0] <= w_next;
        end
    end

    // output register
    assign o_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_fire && i_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_emit) begin
            r_out_value  <= i_ctl.new_pair ? t_field'(w_oldest_ext[FIELD_W-1:0])
                                           : i_ctl.above_value;
            r_from_above <= !i_ctl.new_pair;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_value  = r_out_value;
    assign o_out.from_above = r_from_above;

endmodule
`default_nettype wire

FILE: dv/systolic_mac_pe_with_drain_test.sv
`timescale 1ns / 100ps
`default_nettype none
module systolic_mac_pe_with_drain_test;
    import smpe_pkg::*;

    localparam int unsigned LANES     = 4;
    localparam int unsigned SUM_DEPTH = 8;
    // settling time after the last expected result, with a comfortable margin
    localparam int unsigned SETTLE_CYCLES = 8;

    // one input transaction as the feeders present it
    typedef struct {
        t_field act [LANES];
        t_field wt [LANES];
        logic   new_pair;
        logic   above_valid;
        t_field above_value;
    } t_pe_item;

    // one output transaction: an own drained sum or a forwarded one
    typedef struct {
        t_field value;
        logic   from_above;
    } t_pe_result;

    logic i_clk;
    logic i_rst_n;

    smpe_in_if  in_if ();
    smpe_out_if out_if ();
    smpe_cfg_if cfg_if ();

    systolic_mac_pe_with_drain #(
        .LANES      (LANES),
        .SUM_DEPTH  (SUM_DEPTH),
        .DATA_WIDTH (32)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // predictor state: running sums (entry 0 newest) and the upper port enable
    logic [31:0] run_sums [SUM_DEPTH];
    logic        upper_en;

    // results still owed by the block, oldest first
    t_pe_result drain_q [$];
    t_pe_result exp_res;
    int unsigned mismatch_count;

    // sender burst control and receiver stall control
    bit          tx_gaps;
    int unsigned burst_left;
    bit          rx_stalls;
    int unsigned stall_left;

    // clock, period 4 ns
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard limit on the run, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // predictor: emit or forward, then fold the lane dot product into the
    // oldest sum (or start afresh) and shift the new sum in at the front
    function automatic void mac_update(input t_pe_item it);
        logic [31:0] oldest;
        logic [31:0] dot;
        t_pe_result  r;
        oldest = run_sums[SUM_DEPTH-1];
        if (it.new_pair) begin
            r.value      = oldest;
            r.from_above = 1'b0;
            drain_q.push_back(r);
        end else if (it.above_valid && upper_en) begin
            r.value      = it.above_value;
            r.from_above = 1'b1;
            drain_q.push_back(r);
        end
        // products and sums wrap at 32 bits
        dot = '0;
        for (int i = 0; i < LANES; i++) begin
            dot = dot + it.act[i] * it.wt[i];
        end
        for (int i = SUM_DEPTH - 1; i >= 1; i--) begin
            run_sums[i] = run_sums[i-1];
        end
        run_sums[0] = it.new_pair ? dot : dot + oldest;
    endfunction

    // lane and offer values biased towards the corners
    function automatic t_field rand_field();
        case ($urandom_range(0, 9))
            0: begin
                return 32'h8000_0000;
            end
            1: begin
                return 32'h7fff_ffff;
            end
            2: begin
                return '0;
            end
            3: begin
                return '1;
            end
            4, 5: begin
                return t_field'($signed($urandom_range(0, 511)) - 256);
            end
            default: begin
                return t_field'($urandom);
            end
        endcase
    endfunction

    function automatic t_pe_item make_item(input logic np, input logic av);
        t_pe_item it;
        for (int i = 0; i < LANES; i++) begin
            it.act[i] = rand_field();
            it.wt[i]  = rand_field();
        end
        it.new_pair    = np;
        it.above_valid = av;
        it.above_value = rand_field();
        return it;
    endfunction

    // receiver: ready on its own stall pattern, runs of stalls of random length
    always @(negedge i_clk) begin
        if (!rx_stalls) begin
            out_if.ready = 1'b1;
        end else if (stall_left != 0) begin
            out_if.ready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            out_if.ready = 1'b0;
            stall_left   = $urandom_range(0, 7);
        end else begin
            out_if.ready = 1'b1;
        end
    end

    // checker: every accepted output transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (drain_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected result value=%h from_above=%b", $realtime,
                             out_if.out_value, out_if.from_above);
                end
            end else begin
                exp_res = drain_q.pop_front();
                if (out_if.out_value !== exp_res.value ||
                    out_if.from_above !== exp_res.from_above) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: mismatch value exp=%h got=%h from_above exp=%b got=%b",
                                 $realtime, exp_res.value, out_if.out_value,
                                 exp_res.from_above, out_if.from_above);
                    end
                end
            end
        end
    end

    // send one input transaction; entered and left at a falling edge
    task automatic send_item(input t_pe_item it);
        if (tx_gaps && burst_left == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        in_if.act_lane0   = it.act[0];
        in_if.act_lane1   = it.act[1];
        in_if.act_lane2   = it.act[2];
        in_if.act_lane3   = it.act[3];
        in_if.wt_lane0    = it.wt[0];
        in_if.wt_lane1    = it.wt[1];
        in_if.wt_lane2    = it.wt[2];
        in_if.wt_lane3    = it.wt[3];
        in_if.new_pair    = it.new_pair;
        in_if.above_valid = it.above_valid;
        in_if.above_value = it.above_value;
        in_if.valid       = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        mac_update(it);
        @(negedge i_clk);
        if (burst_left != 0) begin
            burst_left--;
        end
    endtask

    // idle the input and let everything owed come out, plus the pipe latency
    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (drain_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write only with the block idle
    task automatic write_above_enabled(input logic en);
        wait_drained();
        cfg_if.above_enabled = en;
        cfg_if.valid         = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        upper_en = en;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // mostly well-formed pair blocks: SUM_DEPTH fresh sums, then up to three
    // further passes accumulating into them with random offers from above;
    // the rest is loose noise with any mix of flags
    task automatic run_pair_blocks(input int unsigned n_items);
        int unsigned sent;
        int unsigned passes;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                passes = $urandom_range(1, 4);
                for (int j = 0; j < passes * SUM_DEPTH; j++) begin
                    send_item(make_item(j < SUM_DEPTH, 1'($urandom_range(0, 1))));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    send_item(make_item(1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1))));
                    sent++;
                end
            end
        end
    endtask

    // corner lanes, every flag combination, offers in each situation
    task automatic test_directed_corners();
        t_pe_item it;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        // fresh sums from reset zeros, lanes at the extremes
        it = make_item(1'b1, 1'b0);
        for (int i = 0; i < LANES; i++) begin
            it.act[i] = 32'h7fff_ffff;
            it.wt[i]  = 32'h7fff_ffff;
        end
        send_item(it);
        for (int i = 0; i < LANES; i++) begin
            it.act[i] = 32'h8000_0000;
            it.wt[i]  = 32'h8000_0000;
        end
        send_item(it);
        for (int i = 0; i < LANES; i++) begin
            it.act[i] = 32'h8000_0000;
            it.wt[i]  = 32'h7fff_ffff;
        end
        send_item(it);
        for (int i = 0; i < LANES; i++) begin
            it.act[i] = '1;
            it.wt[i]  = '1;
        end
        send_item(it);
        // offer while a new pair starts: not taken, own sum comes out
        it = make_item(1'b1, 1'b1);
        for (int i = 0; i < LANES; i++) begin
            it.act[i] = '0;
            it.wt[i]  = '0;
        end
        send_item(it);
        repeat (3) send_item(make_item(1'b1, 1'b0));
        // forwarding from above, offers at the extremes, and silent items
        it = make_item(1'b0, 1'b1);
        it.above_value = 32'h8000_0000;
        send_item(it);
        send_item(make_item(1'b0, 1'b0));
        it = make_item(1'b0, 1'b1);
        it.above_value = 32'h7fff_ffff;
        send_item(it);
        repeat (5) send_item(make_item(1'b0, 1'($urandom_range(0, 1))));
        // drain the sums accumulated over two passes
        repeat (SUM_DEPTH) send_item(make_item(1'b1, 1'b0));
        // upper port disabled: offer ignored, only the new pair emits its own sum
        write_above_enabled(1'b0);
        send_item(make_item(1'b0, 1'b1));
        send_item(make_item(1'b1, 1'b1));
        write_above_enabled(1'b1);
        send_item(make_item(1'b0, 1'b1));
    endtask

    // upper port enabled, a clean stretch first, then bursts and stalls
    task automatic test_accumulate_with_upper();
        write_above_enabled(1'b1);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        run_pair_blocks(100);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        run_pair_blocks(400);
    endtask

    // edge element: nothing above, offers must be ignored
    task automatic test_accumulate_no_upper();
        write_above_enabled(1'b0);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        run_pair_blocks(300);
    endtask

    // several phases switching the upper port between them
    task automatic test_upper_toggle();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        for (int p = 0; p < 4; p++) begin
            write_above_enabled(p[0]);
            run_pair_blocks(80);
        end
    endtask

    initial begin
        // every input known from time zero
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.act_lane0      = '0;
        in_if.act_lane1      = '0;
        in_if.act_lane2      = '0;
        in_if.act_lane3      = '0;
        in_if.wt_lane0       = '0;
        in_if.wt_lane1       = '0;
        in_if.wt_lane2       = '0;
        in_if.wt_lane3       = '0;
        in_if.new_pair       = 1'b0;
        in_if.above_valid    = 1'b0;
        in_if.above_value    = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.above_enabled = 1'b1;
        out_if.ready         = 1'b1;
        tx_gaps              = 1'b0;
        rx_stalls            = 1'b0;
        burst_left           = 0;
        stall_left           = 0;
        mismatch_count       = 0;
        // predictor state as after reset
        for (int i = 0; i < SUM_DEPTH; i++) begin
            run_sums[i] = '0;
        end
        upper_en = 1'b1;

        // synchronous reset held, then released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        test_accumulate_with_upper();
        test_accumulate_no_upper();
        test_upper_toggle();

        rx_stalls = 1'b0;
        wait_drained();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
sv/smpe_pkg.sv
sv/smpe_ifs.sv
sv/smpe_lane.sv
sv/smpe_merge.sv
sv/smpe_acc.sv
sv/systolic_mac_pe_with_drain.sv
dv/systolic_mac_pe_with_drain_test.sv
